// ===== hdl/pgw_pkg.sv =====
// shared types, constants and helpers of the four-level page table walker
package pgw_pkg;

    localparam logic [63:0] DMAP_RESET = 64'hFFFF_873B_0000_0000;

    // item codes on the op field
    localparam logic OP_REQ = 1'b0;
    localparam logic OP_RSP = 1'b1;

    // table levels, named by the entry that is awaited
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    // page size codes
    localparam logic [1:0] PSZ_4K = 2'd0;
    localparam logic [1:0] PSZ_2M = 2'd1;
    localparam logic [1:0] PSZ_1G = 2'd2;

    // entry bit positions
    localparam int PRESENT_BIT = 0;
    localparam int PS_BIT      = 7;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_PROTO = 2'd3
    } t_kind;

    // classified input item, as it travels from front to back
    typedef struct packed {
        logic        is_rsp;
        logic        fault;
        logic        ps;
        logic [39:0] frame;
        logic [47:0] va;
        logic [63:0] addr;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] read_addr;
        logic [51:0] phys_addr;
        logic [1:0]  page_size_code;
        logic [1:0]  fault_level;
    } t_result;

    // 9-bit table index of a virtual address at a given level
    function automatic logic [8:0] level_index(input logic [47:0] va, input logic [1:0] level);
        logic [8:0] idx;
        case (level)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// ===== hdl/pgw_front.sv =====
// front end: accepts items, classifies them and queues them for the walk engine
module pgw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_op,
    input  logic [47:0]        i_virt_addr,
    input  logic [63:0]        i_root_table_addr,
    input  logic [63:0]        i_entry_data,
    input  logic               i_read_ok,
    input  logic [63:0]        i_dmap_base,
    output logic               o_item_valid,
    output pgw_pkg::t_item     o_item,
    input  logic               i_item_take
);

    pgw_pkg::t_item r_q [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;

    pgw_pkg::t_item n_item;
    logic           wr;
    logic           rd;

    always_comb begin
        n_item.is_rsp = i_op;
        n_item.fault  = !i_read_ok || !i_entry_data[pgw_pkg::PRESENT_BIT];
        n_item.ps     = i_entry_data[pgw_pkg::PS_BIT];
        n_item.frame  = i_entry_data[51:12];
        n_item.va     = i_virt_addr;
        // response: direct-map base plus frame; request: level-4 entry address
        if (i_op) begin
            n_item.addr = i_dmap_base + {12'd0, i_entry_data[51:12], 12'd0};
        end else begin
            n_item.addr = i_root_table_addr
                + {52'd0, pgw_pkg::level_index(i_virt_addr, pgw_pkg::LVL_PML4), 3'd0};
        end
    end

    assign full         = (r_count == 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rptr];
    assign wr           = push && !full;
    assign rd           = o_item_valid && i_item_take;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (wr) begin
                r_wptr <= !r_wptr;
            end
            if (rd) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

// ===== hdl/pgw_back.sv =====
// walk engine: holds the walk state, forms each result and queues it
module pgw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  pgw_pkg::t_item     i_item,
    output logic               o_item_take,
    output logic               empty,
    input  logic               pop,
    output pgw_pkg::t_result   o_result
);

    pgw_pkg::t_result r_rq [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    logic             r_busy;
    logic [1:0]       r_level;
    logic [47:0]      r_va;

    logic             n_busy;
    logic [1:0]       n_level;
    logic [47:0]      n_va;
    pgw_pkg::t_result n_res;
    logic [1:0]       next_level;
    logic             take;
    logic             rd;

    assign take        = i_item_valid && (r_count != 2'd2);
    assign o_item_take = take;
    assign empty       = (r_count == 2'd0);
    assign o_result    = r_rq[r_rptr];
    assign rd          = pop && !empty;
    assign next_level  = r_level + 2'd1;

    always_comb begin
        n_busy  = r_busy;
        n_level = r_level;
        n_va    = r_va;
        n_res   = '{kind: pgw_pkg::KIND_PROTO, read_addr: 64'd0, phys_addr: 52'd0,
                    page_size_code: pgw_pkg::PSZ_4K, fault_level: pgw_pkg::LVL_PML4};
        if (!i_item.is_rsp) begin
            if (!r_busy) begin
                n_busy          = 1'b1;
                n_level         = pgw_pkg::LVL_PML4;
                n_va            = i_item.va;
                n_res.kind      = pgw_pkg::KIND_READ;
                n_res.read_addr = i_item.addr;
            end
        end else if (r_busy) begin
            if (i_item.fault) begin
                n_busy            = 1'b0;
                n_level           = pgw_pkg::LVL_PML4;
                n_res.kind        = pgw_pkg::KIND_FAULT;
                n_res.fault_level = r_level;
            end else if (r_level == pgw_pkg::LVL_PDPT && i_item.ps) begin
                n_busy               = 1'b0;
                n_level              = pgw_pkg::LVL_PML4;
                n_res.kind           = pgw_pkg::KIND_DONE;
                n_res.phys_addr      = {i_item.frame[39:18], r_va[29:0]};
                n_res.page_size_code = pgw_pkg::PSZ_1G;
            end else if (r_level == pgw_pkg::LVL_PD && i_item.ps) begin
                n_busy               = 1'b0;
                n_level              = pgw_pkg::LVL_PML4;
                n_res.kind           = pgw_pkg::KIND_DONE;
                n_res.phys_addr      = {i_item.frame[39:9], r_va[20:0]};
                n_res.page_size_code = pgw_pkg::PSZ_2M;
            end else if (r_level == pgw_pkg::LVL_PT) begin
                n_busy               = 1'b0;
                n_level              = pgw_pkg::LVL_PML4;
                n_res.kind           = pgw_pkg::KIND_DONE;
                n_res.phys_addr      = {i_item.frame, r_va[11:0]};
                n_res.page_size_code = pgw_pkg::PSZ_4K;
            end else begin
                n_level         = next_level;
                n_res.kind      = pgw_pkg::KIND_READ;
                n_res.read_addr = i_item.addr
                    + {52'd0, pgw_pkg::level_index(r_va, next_level), 3'd0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rq[r_wptr] <= n_res;
            r_va         <= n_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= pgw_pkg::LVL_PML4;
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (take) begin
                r_busy  <= n_busy;
                r_level <= n_level;
                r_wptr  <= !r_wptr;
            end
            if (rd) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, take} - {1'b0, rd};
        end
    end

    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_item.is_rsp && !r_busy |=> r_busy && r_level == pgw_pkg::LVL_PML4)
        else $error("walk did not start on an idle request");

    a_busy_request_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_item.is_rsp && r_busy |=> r_busy && $stable(r_level) && $stable(r_va))
        else $error("request while busy disturbed the walk");

    a_fault_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.is_rsp && r_busy && i_item.fault |=> !r_busy)
        else $error("fault did not end the walk");

    a_result_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue overflow");

endmodule

// ===== hdl/four_level_page_table_walker.sv =====
// top level of the four-level page table walker
//
// walks an x86-64 four-level page table, one walk at a time. a translate
// request (op 0) starts a walk and yields a read of root + pml4 index * 8;
// each read response (op 1) yields the next read (direct-map base + 4K frame
// + next index * 8), a finished translation (1G at pdpt, 2M at pd, 4K at pt),
// or a fault naming the awaited level. a request while a walk is open, or a
// response with none open, yields a protocol error and changes nothing.
// every accepted item gives exactly one result. the block takes one item
// per cycle while full is low: a front stage classifies and queues items
// (two entries), and the walk engine handles one queued item per cycle,
// while its two-entry result queue has room; each item is registered in
// the front queue and its result then in the result queue. the direct-map
// base is written through the cfg channel, which is always ready, and
// must only change while no walk is open and no item is queued
module four_level_page_table_walker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [47:0] i_virt_addr,
    input  logic [63:0] i_root_table_addr,
    input  logic [63:0] i_entry_data,
    input  logic        i_read_ok,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [63:0] o_read_addr,
    output logic [51:0] o_phys_addr,
    output logic [1:0]  o_page_size_code,
    output logic [1:0]  o_fault_level,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    // direct-map base register
    logic [63:0]      r_dmap_base;

    // front to back queue
    logic             item_valid;
    pgw_pkg::t_item   item;
    logic             item_take;
    pgw_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmap_base <= pgw_pkg::DMAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dmap_base <= i_cfg_data;
        end
    end

    // classify and queue incoming transfers
    pgw_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_op              (i_op),
        .i_virt_addr       (i_virt_addr),
        .i_root_table_addr (i_root_table_addr),
        .i_entry_data      (i_entry_data),
        .i_read_ok         (i_read_ok),
        .i_dmap_base       (r_dmap_base),
        .o_item_valid      (item_valid),
        .o_item            (item),
        .i_item_take       (item_take)
    );

    // walk state and result queue
    pgw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .empty        (empty),
        .pop          (pop),
        .o_result     (result)
    );

    assign o_kind           = result.kind;
    assign o_read_addr      = result.read_addr;
    assign o_phys_addr      = result.phys_addr;
    assign o_page_size_code = result.page_size_code;
    assign o_fault_level    = result.fault_level;

endmodule

// ===== tb/walk_checker.sv =====
// checker of the page table walker: watches the channels, predicts each result and compares
module walk_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_op,
    input  logic [47:0] i_virt_addr,
    input  logic [63:0] i_root_table_addr,
    input  logic [63:0] i_entry_data,
    input  logic        i_read_ok,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_read_addr,
    input  logic [51:0] i_phys_addr,
    input  logic [1:0]  i_page_size_code,
    input  logic [1:0]  i_fault_level,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // own copy of the walk state and the register
    logic [63:0] dmap_base;
    logic        walk_open;
    logic [1:0]  walk_lvl;
    logic [47:0] held_va;

    pgw_pkg::t_result pending_results[$];
    pgw_pkg::t_result want;

    function automatic logic [8:0] table_index(input logic [47:0] va, input logic [1:0] lvl);
        logic [47:0] shifted;
        shifted = va >> (39 - 9 * lvl);
        return shifted[8:0];
    endfunction

    function automatic pgw_pkg::t_result walk_outcome(input logic op, input logic [47:0] va,
                                                      input logic [63:0] root,
                                                      input logic [63:0] ent,
                                                      input logic ok);
        pgw_pkg::t_result r;
        r      = '0;
        r.kind = pgw_pkg::KIND_READ;
        if (op == pgw_pkg::OP_REQ) begin
            if (walk_open) begin
                r.kind = pgw_pkg::KIND_PROTO;
            end else begin
                walk_open   = 1'b1;
                walk_lvl    = pgw_pkg::LVL_PML4;
                held_va     = va;
                r.read_addr = root + {52'd0, table_index(va, pgw_pkg::LVL_PML4), 3'b000};
            end
        end else if (!walk_open) begin
            r.kind = pgw_pkg::KIND_PROTO;
        end else if (!ok || !ent[pgw_pkg::PRESENT_BIT]) begin
            r.kind        = pgw_pkg::KIND_FAULT;
            r.fault_level = walk_lvl;
            walk_open     = 1'b0;
            walk_lvl      = pgw_pkg::LVL_PML4;
        end else if (walk_lvl == pgw_pkg::LVL_PDPT && ent[pgw_pkg::PS_BIT]) begin
            r.kind           = pgw_pkg::KIND_DONE;
            r.phys_addr      = {ent[51:30], held_va[29:0]};
            r.page_size_code = pgw_pkg::PSZ_1G;
            walk_open        = 1'b0;
            walk_lvl         = pgw_pkg::LVL_PML4;
        end else if (walk_lvl == pgw_pkg::LVL_PD && ent[pgw_pkg::PS_BIT]) begin
            r.kind           = pgw_pkg::KIND_DONE;
            r.phys_addr      = {ent[51:21], held_va[20:0]};
            r.page_size_code = pgw_pkg::PSZ_2M;
            walk_open        = 1'b0;
            walk_lvl         = pgw_pkg::LVL_PML4;
        end else if (walk_lvl == pgw_pkg::LVL_PT) begin
            r.kind           = pgw_pkg::KIND_DONE;
            r.phys_addr      = {ent[51:12], held_va[11:0]};
            r.page_size_code = pgw_pkg::PSZ_4K;
            walk_open        = 1'b0;
            walk_lvl         = pgw_pkg::LVL_PML4;
        end else begin
            walk_lvl    = walk_lvl + 2'd1;
            r.read_addr = dmap_base + {12'd0, ent[51:12], 12'd0}
                          + {52'd0, table_index(held_va, walk_lvl), 3'b000};
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t checker: %s mismatch, expected %h, actual %h",
                     $time, name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dmap_base    = pgw_pkg::DMAP_RESET;
            walk_open    = 1'b0;
            walk_lvl     = pgw_pkg::LVL_PML4;
            held_va      = '0;
            o_fail_count = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                dmap_base = i_cfg_data;
            // result side first: an item pushed at this edge cannot be out yet
            if (i_pop && !i_empty) begin
                if (pending_results.size() == 0) begin
                    $display("%0t checker: result transfer with nothing expected, kind %0d",
                             $time, i_kind);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("kind", 64'(want.kind), 64'(i_kind));
                    compare_field("read_addr", want.read_addr, i_read_addr);
                    compare_field("phys_addr", 64'(want.phys_addr), 64'(i_phys_addr));
                    compare_field("page_size_code", 64'(want.page_size_code),
                                  64'(i_page_size_code));
                    compare_field("fault_level", 64'(want.fault_level), 64'(i_fault_level));
                end
            end
            if (i_push && !i_full)
                pending_results.push_back(walk_outcome(i_op, i_virt_addr, i_root_table_addr,
                                                       i_entry_data, i_read_ok));
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// top of the page table walker testbench: clock, reset, stimulus and verdict
module testbench;

    localparam logic [63:0] PTE_P  = 64'd1 << pgw_pkg::PRESENT_BIT;
    localparam logic [63:0] PTE_PS = 64'd1 << pgw_pkg::PS_BIT;
    localparam logic [63:0] ALL1   = '1;

    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_op;
    logic [47:0] i_virt_addr;
    logic [63:0] i_root_table_addr;
    logic [63:0] i_entry_data;
    logic        i_read_ok;
    logic        empty;
    logic        pop;
    logic [1:0]  o_kind;
    logic [63:0] o_read_addr;
    logic [51:0] o_phys_addr;
    logic [1:0]  o_page_size_code;
    logic [1:0]  o_fault_level;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // long receiver hold-off requests, served by the receiver process
    int hold_asked  = 0;
    int hold_served = 0;
    // no sender gaps while set
    bit tx_calm     = 1'b0;

    four_level_page_table_walker u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_op              (i_op),
        .i_virt_addr       (i_virt_addr),
        .i_root_table_addr (i_root_table_addr),
        .i_entry_data      (i_entry_data),
        .i_read_ok         (i_read_ok),
        .empty             (empty),
        .pop               (pop),
        .o_kind            (o_kind),
        .o_read_addr       (o_read_addr),
        .o_phys_addr       (o_phys_addr),
        .o_page_size_code  (o_page_size_code),
        .o_fault_level     (o_fault_level),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    walk_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_op              (i_op),
        .i_virt_addr       (i_virt_addr),
        .i_root_table_addr (i_root_table_addr),
        .i_entry_data      (i_entry_data),
        .i_read_ok         (i_read_ok),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_kind            (o_kind),
        .i_read_addr       (o_read_addr),
        .i_phys_addr       (o_phys_addr),
        .i_page_size_code  (o_page_size_code),
        .i_fault_level     (o_fault_level),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one item and hold it until the input transfer; called and left at a
    // falling edge with push still high, so back-to-back items need no re-raise
    task automatic send_item(input logic op, input logic [63:0] va, input logic [63:0] root,
                             input logic [63:0] ent, input logic ok);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push              <= 1'b1;
        i_op              <= op;
        i_virt_addr       <= va[47:0];
        i_root_table_addr <= root;
        i_entry_data      <= ent;
        i_read_ok         <= ok;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // sender pauses until every expected result has come back
    task automatic wait_drained();
        push <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // register write, only issued with the block idle
    task automatic write_base(input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one well-formed walk with random entries, now and then a stray request
    // in the middle; it always runs to its end so the block is left idle
    task automatic run_walk(output int n_items);
        logic [63:0] ent;
        logic        ok;
        int          lvl;
        bit          done;
        n_items = 1;
        send_item(pgw_pkg::OP_REQ, rand64(), rand64(), rand64(),
                  1'($urandom_range(0, 1)));
        lvl  = 0;
        done = 1'b0;
        while (!done) begin
            if ($urandom_range(0, 19) == 0) begin
                // request while a walk is open: protocol error, walk goes on
                send_item(pgw_pkg::OP_REQ, rand64(), rand64(), rand64(),
                          1'($urandom_range(0, 1)));
                n_items++;
            end
            ent                       = rand64();
            ok                        = ($urandom_range(0, 19) != 0);
            ent[pgw_pkg::PRESENT_BIT] = ($urandom_range(0, 14) != 0);
            ent[pgw_pkg::PS_BIT]      = ($urandom_range(0, 2) == 0);
            send_item(pgw_pkg::OP_RSP, rand64(), rand64(), ent, ok);
            n_items++;
            if (!ok || !ent[pgw_pkg::PRESENT_BIT])
                done = 1'b1;
            else if ((lvl == 1 || lvl == 2) && ent[pgw_pkg::PS_BIT])
                done = 1'b1;
            else if (lvl == 3)
                done = 1'b1;
            lvl++;
        end
    endtask

    // receiver: random pop stalls, calm stretches, and a long hold-off on request
    initial begin
        int rx_stall;
        int rx_count;
        bit rx_calm;
        pop      = 1'b0;
        rx_stall = 0;
        rx_count = 0;
        rx_calm  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            rx_count++;
            if (rx_count % 300 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (hold_served != hold_asked) begin
                // long hold-off, counted here while the sender keeps going
                pop <= 1'b0;
                hold_served++;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (rx_stall > 0) begin
                pop <= 1'b0;
                rx_stall--;
            end else begin
                pop <= 1'b1;
                if (!rx_calm)
                    rx_stall = pick_gap();
            end
        end
    end

    // stimulus
    initial begin
        logic [63:0] bases[5];
        logic [47:0] va;
        int          n_sent;
        int          k;
        i_rst_n           = 1'b0;
        push              = 1'b0;
        i_op              = pgw_pkg::OP_REQ;
        i_virt_addr       = '0;
        i_root_table_addr = '0;
        i_entry_data      = '0;
        i_read_ok         = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, with the base at its reset value
        // responses with no walk open
        send_item(pgw_pkg::OP_RSP, '0, '0, ALL1, 1'b1);
        send_item(pgw_pkg::OP_RSP, ALL1, ALL1, '0, 1'b0);
        // zero request, stray request while busy, failed read at pml4
        send_item(pgw_pkg::OP_REQ, '0, '0, '0, 1'b0);
        send_item(pgw_pkg::OP_REQ, ALL1, ALL1, ALL1, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, ALL1, 1'b0);
        // all-ones walk: sums wrap, page-size bit ignored at pml4 and at pt
        send_item(pgw_pkg::OP_REQ, ALL1, ALL1, '0, 1'b0);
        send_item(pgw_pkg::OP_RSP, '0, '0, ALL1, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, PTE_P, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, ALL1 & ~PTE_PS, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, ALL1, 1'b1);
        // 1G page at pdpt
        va = 48'h5A5A_C3C3_9696;
        send_item(pgw_pkg::OP_REQ, {16'd0, va}, 64'h0000_0001_2345_6000, '0, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, 64'h0000_0000_0ABC_D001, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, 64'h000F_FFFF_C000_0081, 1'b1);
        // 2M page at pd
        send_item(pgw_pkg::OP_REQ, {16'd0, ~va}, rand64(), '0, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, 64'h8000_0000_1234_5003, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, 64'h0000_0000_0765_4001, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, 64'h0000_1234_5660_0083, 1'b1);
        // entry not present at pdpt
        send_item(pgw_pkg::OP_REQ, rand64(), rand64(), '0, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, PTE_P, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, ALL1 & ~PTE_P, 1'b1);
        // failed read at pd even though present
        send_item(pgw_pkg::OP_REQ, rand64(), rand64(), '0, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, PTE_P, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, PTE_P, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, ALL1, 1'b0);
        // not present at pt
        send_item(pgw_pkg::OP_REQ, rand64(), rand64(), '0, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, PTE_P, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, PTE_P, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, PTE_P, 1'b1);
        send_item(pgw_pkg::OP_RSP, '0, '0, '0, 1'b1);
        wait_drained();

        // random phases, each under its own base setting, extremes included
        bases[0] = '0;
        bases[1] = ALL1;
        bases[2] = rand64();
        bases[3] = 64'hFFFF_8000_0000_0000;
        bases[4] = pgw_pkg::DMAP_RESET;
        for (int ph = 0; ph < 5; ph++) begin
            write_base(bases[ph]);
            // one phase runs against a receiver that holds off, so full must rise
            if (ph == 2) begin
                hold_asked++;
                tx_calm = 1'b1;
            end else begin
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            n_sent = 0;
            while (n_sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // response with no walk open
                    send_item(pgw_pkg::OP_RSP, rand64(), rand64(), rand64(),
                              1'($urandom_range(0, 1)));
                    n_sent++;
                end else begin
                    run_walk(k);
                    n_sent += k;
                end
            end
            wait_drained();
        end

        // let the pipeline settle after the last transfer
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
